// File: hw/rtl/pcent_pkg.sv
`default_nettype none

package pcent_pkg;

    // Coordinate and accumulator widths.
    localparam int COORD_BITS  = 12;
    localparam int AREA_BITS   = 32;
    localparam int MOMENT_BITS = 46;

    // Derived datapath widths.
    localparam int PRODUCT_BITS = 2 * COORD_BITS;          // x0*y1
    localparam int CROSS_BITS   = PRODUCT_BITS + 1;        // signed cross product
    localparam int SUM_BITS     = COORD_BITS + 1;          // x0+x1
    localparam int MOM_TERM_BITS = SUM_BITS + 1 + CROSS_BITS; // (x0+x1)*cross, signed
    localparam int DEN_BITS     = AREA_BITS + 2;           // 3 * |twice area|
    localparam int DIV_BITS     = MOMENT_BITS + 2;         // divider working width
    localparam int STEP_BITS    = $clog2(COORD_BITS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // input transfer this cycle
        logic close_load;  // load the closing edge back to the first vertex
        logic prod;        // edge step 1: coordinate products and sums
        logic cross_acc;   // edge step 2: cross product, area accumulate
        logic mom_mul;     // edge step 3: moment terms
        logic mom_acc;     // edge step 4: moment accumulate
        logic div_prep;    // set up the divide, clear the polygon state
        logic div_sat;     // check quotient overflow
        logic div_step;    // one restoring divide step
        logic out_load;    // load the result register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic have_first;
    } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pcent_dpath.sv
`default_nettype none

module pcent_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pcent_pkg::cmd_t               cmd,
    output pcent_pkg::stat_t                   stat,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_x,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_y,
    output logic [pcent_pkg::COORD_BITS-1:0]   m_centroid_x,
    output logic [pcent_pkg::COORD_BITS-1:0]   m_centroid_y,
    output logic                               m_degenerate
);
    import pcent_pkg::*;

    // Polygon state.
    logic                          have_first_reg;
    logic [COORD_BITS-1:0]         first_x_reg, first_y_reg;
    logic [COORD_BITS-1:0]         prev_x_reg, prev_y_reg;
    logic [AREA_BITS-1:0]          area_reg;
    logic [MOMENT_BITS-1:0]        mom_x_reg, mom_y_reg;

    // Edge operands and intermediate results.
    logic [COORD_BITS-1:0]         ax_reg, ay_reg, bx_reg, by_reg;
    logic [PRODUCT_BITS-1:0]       p0_reg, p1_reg;
    logic [SUM_BITS-1:0]           sx_reg, sy_reg;
    logic signed [CROSS_BITS-1:0]  c_reg;
    logic signed [MOM_TERM_BITS-1:0] mx_reg, my_reg;

    // Divider state.
    logic [DIV_BITS-1:0]           rem_x_reg, rem_y_reg, dsh_reg;
    logic [COORD_BITS-1:0]         q_x_reg, q_y_reg;
    logic                          neg_x_reg, neg_y_reg, sat_x_reg, sat_y_reg, deg_reg;

    // Result register.
    logic [COORD_BITS-1:0]         cx_reg, cy_reg;
    logic                          degenerate_reg;

    logic [CROSS_BITS-1:0]         c_next;
    logic [AREA_BITS-1:0]          area_mag;
    logic [DEN_BITS-1:0]           den_mag;
    logic [MOMENT_BITS-1:0]        mom_x_mag, mom_y_mag;
    logic                          ge_x, ge_y;

    assign stat.have_first = have_first_reg;

    // Cross product of the current edge.
    assign c_next = {1'b0, p0_reg} - {1'b0, p1_reg};

    // Divider setup: magnitudes and the divisor 3 * |twice area|.
    assign area_mag  = area_reg[AREA_BITS-1] ? (~area_reg + 1'b1) : area_reg;
    assign den_mag   = {2'b00, area_mag} + {1'b0, area_mag, 1'b0};
    assign mom_x_mag = mom_x_reg[MOMENT_BITS-1] ? (~mom_x_reg + 1'b1) : mom_x_reg;
    assign mom_y_mag = mom_y_reg[MOMENT_BITS-1] ? (~mom_y_reg + 1'b1) : mom_y_reg;

    // Restoring divide compare.
    assign ge_x = (rem_x_reg >= dsh_reg);
    assign ge_y = (rem_y_reg >= dsh_reg);

    // Polygon state, cleared by reset and when the divide is set up.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_first_reg <= 1'b0;
            area_reg       <= '0;
            mom_x_reg      <= '0;
            mom_y_reg      <= '0;
        end else begin
            if (cmd.accept) begin
                have_first_reg <= 1'b1;
            end
            if (cmd.cross_acc) begin
                area_reg <= area_reg
                    + {{(AREA_BITS-CROSS_BITS){c_next[CROSS_BITS-1]}}, c_next};
            end
            if (cmd.mom_acc) begin
                mom_x_reg <= mom_x_reg
                    + {{(MOMENT_BITS-MOM_TERM_BITS){mx_reg[MOM_TERM_BITS-1]}}, mx_reg};
                mom_y_reg <= mom_y_reg
                    + {{(MOMENT_BITS-MOM_TERM_BITS){my_reg[MOM_TERM_BITS-1]}}, my_reg};
            end
            if (cmd.div_prep) begin
                have_first_reg <= 1'b0;
                area_reg       <= '0;
                mom_x_reg      <= '0;
                mom_y_reg      <= '0;
            end
        end
    end

    // Vertex registers and edge operands.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            prev_x_reg <= s_vertex_x;
            prev_y_reg <= s_vertex_y;
            if (have_first_reg) begin
                ax_reg <= prev_x_reg;
                ay_reg <= prev_y_reg;
                bx_reg <= s_vertex_x;
                by_reg <= s_vertex_y;
            end else begin
                first_x_reg <= s_vertex_x;
                first_y_reg <= s_vertex_y;
            end
        end
        if (cmd.close_load) begin
            ax_reg <= prev_x_reg;
            ay_reg <= prev_y_reg;
            bx_reg <= first_x_reg;
            by_reg <= first_y_reg;
        end
    end

    // Edge arithmetic, at most one multiply level per step.
    always_ff @(posedge aclk) begin
        if (cmd.prod) begin
            p0_reg <= ax_reg * by_reg;
            p1_reg <= bx_reg * ay_reg;
            sx_reg <= {1'b0, ax_reg} + {1'b0, bx_reg};
            sy_reg <= {1'b0, ay_reg} + {1'b0, by_reg};
        end
        if (cmd.cross_acc) begin
            c_reg <= $signed(c_next);
        end
        if (cmd.mom_mul) begin
            mx_reg <= $signed({1'b0, sx_reg}) * c_reg;
            my_reg <= $signed({1'b0, sy_reg}) * c_reg;
        end
    end

    // Two restoring dividers sharing one shifted divisor.
    always_ff @(posedge aclk) begin
        if (cmd.div_prep) begin
            rem_x_reg <= {2'b00, mom_x_mag};
            rem_y_reg <= {2'b00, mom_y_mag};
            dsh_reg   <= {{(DIV_BITS-DEN_BITS-COORD_BITS){1'b0}}, den_mag,
                          {COORD_BITS{1'b0}}};
            neg_x_reg <= mom_x_reg[MOMENT_BITS-1] ^ area_reg[AREA_BITS-1];
            neg_y_reg <= mom_y_reg[MOMENT_BITS-1] ^ area_reg[AREA_BITS-1];
            deg_reg   <= (area_reg == '0);
        end
        if (cmd.div_sat) begin
            sat_x_reg <= ge_x;
            sat_y_reg <= ge_y;
            dsh_reg   <= dsh_reg >> 1;
        end
        if (cmd.div_step) begin
            if (ge_x) begin
                rem_x_reg <= rem_x_reg - dsh_reg;
            end
            if (ge_y) begin
                rem_y_reg <= rem_y_reg - dsh_reg;
            end
            q_x_reg <= {q_x_reg[COORD_BITS-2:0], ge_x};
            q_y_reg <= {q_y_reg[COORD_BITS-2:0], ge_y};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Result register: zero for a negative or degenerate result, full scale on overflow.
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            degenerate_reg <= deg_reg;
            if (deg_reg || neg_x_reg) begin
                cx_reg <= '0;
            end else if (sat_x_reg) begin
                cx_reg <= '1;
            end else begin
                cx_reg <= q_x_reg;
            end
            if (deg_reg || neg_y_reg) begin
                cy_reg <= '0;
            end else if (sat_y_reg) begin
                cy_reg <= '1;
            end else begin
                cy_reg <= q_y_reg;
            end
        end
    end

    assign m_centroid_x = cx_reg;
    assign m_centroid_y = cy_reg;
    assign m_degenerate = degenerate_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pcent_ctrl.sv
`default_nettype none

module pcent_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_last_vertex,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire pcent_pkg::stat_t stat,
    output pcent_pkg::cmd_t       cmd
);
    import pcent_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_CROSS,
        ST_MUL,
        ST_ACC,
        ST_CLOSE,
        ST_PREP,
        ST_SAT,
        ST_STEP,
        ST_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic                 last_reg, last_next;
    logic                 closing_reg, closing_next;
    logic [STEP_BITS-1:0] step_cnt_reg, step_cnt_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 accept;

    // A new vertex is taken when idle, or while the last step of an ordinary edge runs.
    assign s_ready = (state_reg == ST_IDLE) || ((state_reg == ST_ACC) && !last_reg);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // Next state and commands.
    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        closing_next  = closing_reg;
        step_cnt_next = step_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        cmd           = '0;
        cmd.accept    = accept;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    last_next    = s_last_vertex;
                    closing_next = 1'b0;
                    if (stat.have_first) begin
                        state_next = ST_PROD;
                    end else if (s_last_vertex) begin
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_PROD: begin
                cmd.prod   = 1'b1;
                state_next = ST_CROSS;
            end
            ST_CROSS: begin
                cmd.cross_acc = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.mom_mul = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                cmd.mom_acc = 1'b1;
                if (closing_reg) begin
                    state_next = ST_PREP;
                end else if (last_reg) begin
                    state_next = ST_CLOSE;
                end else if (accept) begin
                    // Back-to-back vertex; have_first is always set here.
                    last_next  = s_last_vertex;
                    state_next = ST_PROD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLOSE: begin
                cmd.close_load = 1'b1;
                closing_next   = 1'b1;
                state_next     = ST_PROD;
            end
            ST_PREP: begin
                cmd.div_prep = 1'b1;
                state_next   = ST_SAT;
            end
            ST_SAT: begin
                cmd.div_sat   = 1'b1;
                step_cnt_next = STEP_BITS'(COORD_BITS - 1);
                state_next    = ST_STEP;
            end
            ST_STEP: begin
                cmd.div_step  = 1'b1;
                step_cnt_next = step_cnt_reg - 1'b1;
                if (step_cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Wait for the result register to be free.
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            last_reg     <= 1'b0;
            closing_reg  <= 1'b0;
            step_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            closing_reg  <= closing_next;
            step_cnt_reg <= step_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/polygon_centroid.sv
`default_nettype none

// Area centroid of a polygon by the shoelace formula. Vertices arrive one per
// transfer on the s_ channel, with s_last_vertex set on the closing vertex; one
// result per polygon leaves on the m_ channel as the centroid truncated toward
// zero, clamped to the coordinate range, or zeros with m_degenerate set when the
// signed area is zero. All sums are exact integers. Each edge runs through a
// four-step multiply and accumulate sequence; the first vertex of a polygon
// adds no edge. The last vertex adds the closing edge and a restoring divide
// (an overflow check, then one step per quotient bit), and the next polygon
// can start once the result is loaded.
// A waiting result does not stop the following polygon's vertices.
module polygon_centroid (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_x,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_y,
    input  wire logic                             s_last_vertex,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    output logic [pcent_pkg::COORD_BITS-1:0]      m_centroid_x,
    output logic [pcent_pkg::COORD_BITS-1:0]      m_centroid_y,
    output logic                                  m_degenerate,
    output logic                                  m_valid,
    input  wire logic                             m_ready
);
    import pcent_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    pcent_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_last_vertex (s_last_vertex),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // Accumulators, divider and result register.
    pcent_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_vertex_x   (s_vertex_x),
        .s_vertex_y   (s_vertex_y),
        .m_centroid_x (m_centroid_x),
        .m_centroid_y (m_centroid_y),
        .m_degenerate (m_degenerate)
    );

endmodule

`default_nettype wire

// File: hw/rtl/pcent_checker.sv
`default_nettype none

module pcent_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_x,
    input wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_y,
    input wire logic                             s_last_vertex,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic [pcent_pkg::COORD_BITS-1:0] m_centroid_x,
    input wire logic [pcent_pkg::COORD_BITS-1:0] m_centroid_y,
    input wire logic                             m_degenerate,
    input wire logic                             m_valid,
    input wire logic                             m_ready
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_centroid_x)
            && $stable(m_centroid_y) && $stable(m_degenerate))
        else $error("result changed while stalled");

    // A degenerate polygon reports a zero centroid.
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_centroid_x == '0 && m_centroid_y == '0)
        else $error("degenerate result with nonzero centroid");

    // The closing vertex always starts a busy phase.
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_vertex |=> !s_ready)
        else $error("input ready right after the closing vertex");

    // A new result appears only at the end of a busy phase.
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while accepting vertices");

endmodule

bind polygon_centroid pcent_checker u_pcent_checker (.*);

`default_nettype wire

// File: tb/polygon_centroid_checker.sv
`default_nettype none

// Watches both channels of the centroid block, keeps its own shoelace
// accumulators, and checks every result transfer against the oldest
// outstanding polygon.
module polygon_centroid_checker (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_x,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] s_vertex_y,
    input  wire logic                             s_last_vertex,
    input  wire logic                             s_valid,
    input  wire logic                             s_ready,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] m_centroid_x,
    input  wire logic [pcent_pkg::COORD_BITS-1:0] m_centroid_y,
    input  wire logic                             m_degenerate,
    input  wire logic                             m_valid,
    input  wire logic                             m_ready,
    output int                                    fail_count,
    output int                                    pending_count,
    output int                                    centroid_count,
    output int                                    degenerate_count
);
    import pcent_pkg::*;

    localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

    typedef struct {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic                  degen;
    } centroid_t;

    // Polygons closed on the input side whose centroid has not left yet.
    centroid_t expected_centroids[$];

    // Running polygon state.
    logic [COORD_BITS-1:0]         first_x = '0;
    logic [COORD_BITS-1:0]         first_y = '0;
    logic [COORD_BITS-1:0]         prev_x = '0;
    logic [COORD_BITS-1:0]         prev_y = '0;
    logic                          started = 1'b0;
    logic signed [AREA_BITS-1:0]   area_acc = '0;
    logic signed [MOMENT_BITS-1:0] moment_x_acc = '0;
    logic signed [MOMENT_BITS-1:0] moment_y_acc = '0;

    int fails = 0;
    int pending = 0;
    int centroids = 0;
    int degenerates = 0;

    assign fail_count       = fails;
    assign pending_count    = pending;
    assign centroid_count   = centroids;
    assign degenerate_count = degenerates;

    // Adds one edge: cross product to the doubled area, and the cross
    // product weighted by the coordinate sums to the two moments.
    function automatic void accumulate_edge(input logic [COORD_BITS-1:0] x0,
                                            input logic [COORD_BITS-1:0] y0,
                                            input logic [COORD_BITS-1:0] x1,
                                            input logic [COORD_BITS-1:0] y1);
        longint cross_prod;
        longint term_x;
        longint term_y;
        cross_prod = longint'(x0) * longint'(y1) - longint'(x1) * longint'(y0);
        term_x = (longint'(x0) + longint'(x1)) * cross_prod;
        term_y = (longint'(y0) + longint'(y1)) * cross_prod;
        area_acc     = area_acc + cross_prod[AREA_BITS-1:0];
        moment_x_acc = moment_x_acc + term_x[MOMENT_BITS-1:0];
        moment_y_acc = moment_y_acc + term_y[MOMENT_BITS-1:0];
    endfunction

    // Quotient truncated toward zero, then clamped into the coordinate range.
    function automatic logic [COORD_BITS-1:0] clamp_quotient(
            input logic signed [MOMENT_BITS-1:0] moment, input longint den);
        longint num;
        longint quo;
        num = longint'(moment);
        quo = (num < 0 ? -num : num) / (den < 0 ? -den : den);
        if ((num < 0) != (den < 0)) begin
            return '0;
        end
        if (quo > longint'(COORD_MAX)) begin
            return COORD_MAX;
        end
        return quo[COORD_BITS-1:0];
    endfunction

    // Takes one accepted vertex; on the closing vertex the centroid is queued
    // and the polygon state is cleared.
    function automatic void take_vertex(input logic [COORD_BITS-1:0] x,
                                        input logic [COORD_BITS-1:0] y,
                                        input logic closing);
        centroid_t res;
        longint den;
        if (!started) begin
            first_x = x;
            first_y = y;
            started = 1'b1;
        end else begin
            accumulate_edge(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
        if (closing) begin
            accumulate_edge(x, y, first_x, first_y);
            den = 3 * longint'(area_acc);
            if (den == 0) begin
                res.cx = '0;
                res.cy = '0;
                res.degen = 1'b1;
            end else begin
                res.cx = clamp_quotient(moment_x_acc, den);
                res.cy = clamp_quotient(moment_y_acc, den);
                res.degen = 1'b0;
            end
            expected_centroids.insert(expected_centroids.size(), res);
            first_x = '0;
            first_y = '0;
            prev_x = '0;
            prev_y = '0;
            started = 1'b0;
            area_acc = '0;
            moment_x_acc = '0;
            moment_y_acc = '0;
        end
    endfunction

    // Result transfers are checked before this edge's vertex is taken, so a
    // result can never be matched to the vertex accepted with it.
    always @(posedge aclk) begin
        centroid_t want;
        int errs;
        errs = 0;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_centroids.size() == 0) begin
                    $error("result transfer with no polygon outstanding: %s%0d y=%0d d=%0b",
                           "x=", m_centroid_x, m_centroid_y, m_degenerate);
                    errs++;
                end else begin
                    want = expected_centroids.pop_front();
                    if (m_centroid_x !== want.cx) begin
                        $error("centroid_x mismatch: expected %0d, actual %0d",
                               want.cx, m_centroid_x);
                        errs++;
                    end
                    if (m_centroid_y !== want.cy) begin
                        $error("centroid_y mismatch: expected %0d, actual %0d",
                               want.cy, m_centroid_y);
                        errs++;
                    end
                    if (m_degenerate !== want.degen) begin
                        $error("degenerate mismatch: expected %0b, actual %0b",
                               want.degen, m_degenerate);
                        errs++;
                    end
                    if (want.degen) begin
                        degenerates <= degenerates + 1;
                    end
                end
                centroids <= centroids + 1;
            end
            if (s_valid && s_ready) begin
                take_vertex(s_vertex_x, s_vertex_y, s_last_vertex);
            end
        end
        fails <= fails + errs;
        pending <= expected_centroids.size();
    end

endmodule

`default_nettype wire

// File: tb/tb_polygon_centroid.sv
`default_nettype none

module tb_polygon_centroid;
    import pcent_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int COORD_TOP      = (1 << COORD_BITS) - 1;
    localparam int VERTEX_TARGET  = 1950;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic [COORD_BITS-1:0] s_vertex_x = '0;
    logic [COORD_BITS-1:0] s_vertex_y = '0;
    logic                  s_last_vertex = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] m_centroid_x;
    logic [COORD_BITS-1:0] m_centroid_y;
    logic                  m_degenerate;
    logic                  m_valid;
    logic                  m_ready = 1'b0;

    int  fail_count;
    int  pending_count;
    int  centroid_count;
    int  degenerate_count;
    int  idle_cycles = 0;
    int  vertices_sent = 0;
    int  polygons_sent = 0;
    int  longest_polygon = 0;
    logic steady = 1'b0;

    polygon_centroid DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_vertex_x    (s_vertex_x),
        .s_vertex_y    (s_vertex_y),
        .s_last_vertex (s_last_vertex),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .m_centroid_x  (m_centroid_x),
        .m_centroid_y  (m_centroid_y),
        .m_degenerate  (m_degenerate),
        .m_valid       (m_valid),
        .m_ready       (m_ready)
    );

    polygon_centroid_checker CHECK (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_vertex_x       (s_vertex_x),
        .s_vertex_y       (s_vertex_y),
        .s_last_vertex    (s_last_vertex),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .m_centroid_x     (m_centroid_x),
        .m_centroid_y     (m_centroid_y),
        .m_degenerate     (m_degenerate),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .centroid_count   (centroid_count),
        .degenerate_count (degenerate_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // The result side stalls with a probability of about 13 percent, except in the
    // steady stretch.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99, 0) >= 13);
    end

    // Ends the run when no transfer happens on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One vertex transfer, preceded by random idle cycles outside the steady
    // stretch. Valid stays high across back-to-back vertices.
    task automatic send_vertex(input int x, input int y, input logic closing);
        while (!steady && $urandom_range(99, 0) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_vertex_x    <= x[COORD_BITS-1:0];
        s_vertex_y    <= y[COORD_BITS-1:0];
        s_last_vertex <= closing;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        vertices_sent++;
    endtask

    // Sends a whole polygon, flagging the final vertex.
    task automatic send_path(input int xs[$], input int ys[$]);
        for (int i = 0; i < xs.size(); i++) begin
            send_vertex(xs[i], ys[i], i == xs.size() - 1);
        end
        polygons_sent++;
        if (xs.size() > longest_polygon) begin
            longest_polygon = xs.size();
        end
    endtask

    // Simple star-shaped polygon: points walk once around a square of half
    // size r and are pulled toward its center by a random amount. Either
    // winding direction is used.
    task automatic send_star(input int n, input int r);
        int xs[$];
        int ys[$];
        int cx;
        int cy;
        int span;
        int t;
        int side;
        int off;
        int k;
        int x;
        int y;
        logic reverse;
        cx = $urandom_range(COORD_TOP - r, r);
        cy = $urandom_range(COORD_TOP - r, r);
        span = 8 * r;
        t = $urandom_range(span - 1, 0);
        reverse = 1'($urandom_range(1, 0));
        for (int i = 0; i < n; i++) begin
            t = t + $urandom_range((span / n > 1) ? span / n : 1, 1);
            side = (t % span) / (2 * r);
            off = (t % span) % (2 * r);
            case (side)
                0: begin
                    x = cx - r + off;
                    y = cy - r;
                end
                1: begin
                    x = cx + r;
                    y = cy - r + off;
                end
                2: begin
                    x = cx + r - off;
                    y = cy + r;
                end
                default: begin
                    x = cx - r;
                    y = cy + r - off;
                end
            endcase
            k = $urandom_range(8, 5);
            x = cx + (x - cx) * k / 8;
            y = cy + (y - cy) * k / 8;
            if (reverse) begin
                xs.push_front(x);
                ys.push_front(y);
            end else begin
                xs = {xs, x};
                ys = {ys, y};
            end
        end
        send_path(xs, ys);
    endtask

    // Vertices anywhere in the coordinate range; mostly self-intersecting.
    task automatic send_scatter(input int n);
        int xs[$];
        int ys[$];
        for (int i = 0; i < n; i++) begin
            xs = {xs, int'($urandom_range(COORD_TOP, 0))};
            ys = {ys, int'($urandom_range(COORD_TOP, 0))};
        end
        send_path(xs, ys);
    endtask

    initial begin
        int pick;
        int long_left;
        logic drained;
        long_left = 4;
        drained = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed shapes: single vertex at both corners, a two-vertex
        // polygon, the largest triangle in both windings, the full square,
        // collinear points, a balanced bowtie and a lopsided one.
        send_path('{0}, '{0});
        send_path('{COORD_TOP}, '{COORD_TOP});
        send_path('{COORD_TOP, 0}, '{0, COORD_TOP});
        send_path('{0, COORD_TOP, 0}, '{0, 0, COORD_TOP});
        send_path('{0, 0, COORD_TOP}, '{0, COORD_TOP, 0});
        send_path('{0, COORD_TOP, COORD_TOP, 0}, '{0, 0, COORD_TOP, COORD_TOP});
        send_path('{1, 2, COORD_TOP - 1}, '{1, 2, COORD_TOP - 1});
        send_path('{0, COORD_TOP, COORD_TOP, 0}, '{0, COORD_TOP, 0, COORD_TOP});
        send_path('{0, COORD_TOP, COORD_TOP, 0}, '{0, COORD_TOP, 0, 1});

        // Random polygons: mostly simple shapes, then scattered vertices,
        // tiny polygons and a few far beyond the nominal vertex count.
        while (vertices_sent < VERTEX_TARGET) begin
            steady <= (vertices_sent >= 400 && vertices_sent < 700);
            if (!drained && vertices_sent >= 1000) begin
                // Hold the sender until every outstanding centroid has left.
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_count != 0) begin
                    @(posedge aclk);
                end
                drained = 1'b1;
            end
            pick = $urandom_range(99, 0);
            if (pick < 58) begin
                send_star($urandom_range(10, 3),
                          ($urandom_range(9, 0) == 0) ? COORD_TOP / 2
                                                      : $urandom_range(600, 8));
            end else if (pick < 83) begin
                send_scatter($urandom_range(8, 3));
            end else if (pick < 95 || long_left == 0) begin
                send_scatter($urandom_range(2, 1));
            end else begin
                long_left--;
                if (long_left % 2 == 0) begin
                    send_star($urandom_range(130, 65), $urandom_range(COORD_TOP / 2, 1500));
                end else begin
                    send_scatter($urandom_range(130, 65));
                end
            end
        end

        // Let every outstanding centroid drain, then a short tail.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) begin
            @(posedge aclk);
        end
        repeat (30) @(posedge aclk);

        $display("Covered %0d polygons with %0d vertices in all, the longest %0d vertices.",
                 polygons_sent, vertices_sent, longest_polygon);
        $display("Checked %0d centroids, %0d of them degenerate.",
                 centroid_count, degenerate_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/pcent_pkg.sv
hw/rtl/pcent_dpath.sv
hw/rtl/pcent_ctrl.sv
hw/rtl/polygon_centroid.sv
hw/rtl/pcent_checker.sv
tb/polygon_centroid_checker.sv
tb/tb_polygon_centroid.sv
